// File: rtl/core/imuacc_pkg.sv
// Shared types and constants for the IMU acceleration packet decoder.
// Used by imuacc_ctrl, imuacc_dp and imu_accel_packet_decoder_core.
// No dependencies.
package imuacc_pkg;

   localparam logic [7:0]  HdrFirst     = 8'h55;
   localparam logic [7:0]  HdrSecond    = 8'h51;
   localparam logic [3:0]  CheckPos     = 4'd10;
   localparam logic [15:0] GravityReset = 16'd2509;
   localparam logic [19:0] TempRecip    = 20'd986896;
   localparam int          TempShift    = 24;
   localparam logic [14:0] TempOffset   = 15'd3625;
   localparam int          RootSteps    = 17;
   localparam int          CntWidth     = 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_SQUARE,
      ST_ROOT,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic       take_byte;
      logic [1:0] lane;
      logic       scale_en;
      logic       sq_load;
      logic       acc_clr;
      logic       acc_add;
      logic       root_step;
      logic       out_load;
      logic       out_bad;
   } cmd_type;

   typedef struct packed {
      logic at_check;
      logic sum_match;
      logic out_full;
   } sts_type;

endpackage

// File: rtl/core/imu_accel_packet_decoder_core.sv
// Top level of the IMU acceleration packet decoder: register port,
// sequencer and datapath. Depends on imuacc_pkg, imuacc_ctrl and imuacc_dp.
//
// The block takes one serial byte per request and hunts for the header 0x55 0x51,
// collects the eleven-byte acceleration packet and checks its 8-bit sum. Only the
// checksum byte produces a result: scaled x, y and z accelerations, temperature in
// hundredths of a degree and the integer magnitude, or all zeros with checksum_ok
// low on a mismatch. Header and payload bytes are taken one per cycle, also while a
// result waits to be taken. After the checksum byte of a good packet the block
// stalls while the result is made: first on the shared scaling multiplier, then on
// the squaring multiplier and accumulator, then in the one-bit-per-cycle square root
// unit, and last to load the result register. A failed packet skips these steps and
// goes straight to the result register. Either case stalls longer for as long as
// an earlier result has not been taken. gravity_scale sits at byte addresses 0 to 3.
module imu_accel_packet_decoder_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_rx_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [16:0]  rsp_accel_x,
   output logic signed [16:0]  rsp_accel_y,
   output logic signed [16:0]  rsp_accel_z,
   output logic signed [14:0]  rsp_temperature_centi,
   output logic [16:0]         rsp_magnitude,
   output logic                rsp_checksum_ok,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   logic [15:0]         gravity_ff, gravity_in;
   imuacc_pkg::cmd_type cmd;
   imuacc_pkg::sts_type sts;

   always_comb begin
      gravity_in = gravity_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2]) begin
         gravity_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff <= imuacc_pkg::GravityReset;
      end else begin
         gravity_ff <= gravity_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {16'd0, gravity_ff};

   imuacc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   imuacc_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .rx_byte               (req_rx_byte),
      .gravity_scale         (gravity_ff),
      .rsp_stall             (rsp_stall),
      .rsp_valid             (rsp_valid),
      .rsp_accel_x           (rsp_accel_x),
      .rsp_accel_y           (rsp_accel_y),
      .rsp_accel_z           (rsp_accel_z),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_magnitude         (rsp_magnitude),
      .rsp_checksum_ok       (rsp_checksum_ok)
   );

endmodule

// File: rtl/core/imuacc_ctrl.sv
// Sequencer for the packet decoder: byte acceptance and the per-packet
// scale, square and root steps. Depends on imuacc_pkg.
module imuacc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  imuacc_pkg::sts_type sts,
   output imuacc_pkg::cmd_type cmd
);

   localparam int CntWidth = imuacc_pkg::CntWidth;

   imuacc_pkg::state_type                 state_ff, state_in;
   logic [imuacc_pkg::CntWidth-1:0]       cnt_ff, cnt_in;
   logic                                  bad_ff, bad_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + 1'b1;
      bad_in   = bad_ff;
      case (state_ff)
         imuacc_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (req_valid && sts.at_check) begin
               bad_in   = !sts.sum_match;
               state_in = sts.sum_match ? imuacc_pkg::ST_SCALE : imuacc_pkg::ST_OUTPUT;
            end
         end
         imuacc_pkg::ST_SCALE: begin
            if (cnt_ff == CntWidth'(2)) begin
               cnt_in   = '0;
               state_in = imuacc_pkg::ST_SQUARE;
            end
         end
         imuacc_pkg::ST_SQUARE: begin
            if (cnt_ff == CntWidth'(3)) begin
               cnt_in   = '0;
               state_in = imuacc_pkg::ST_ROOT;
            end
         end
         imuacc_pkg::ST_ROOT: begin
            if (cnt_ff == CntWidth'(imuacc_pkg::RootSteps - 1)) begin
               cnt_in   = '0;
               state_in = imuacc_pkg::ST_OUTPUT;
            end
         end
         imuacc_pkg::ST_OUTPUT: begin
            cnt_in = '0;
            if (!sts.out_full) begin
               state_in = imuacc_pkg::ST_IDLE;
            end
         end
         default: begin
            cnt_in   = '0;
            state_in = imuacc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         imuacc_pkg::ST_IDLE: begin
            req_stall     = 1'b0;
            cmd.take_byte = req_valid;
         end
         imuacc_pkg::ST_SCALE: begin
            cmd.scale_en = 1'b1;
            cmd.lane     = cnt_ff[1:0];
         end
         imuacc_pkg::ST_SQUARE: begin
            cmd.sq_load = (cnt_ff != CntWidth'(3));
            cmd.lane    = cnt_ff[1:0];
            cmd.acc_clr = (cnt_ff == '0);
            cmd.acc_add = (cnt_ff != '0);
         end
         imuacc_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
         end
         imuacc_pkg::ST_OUTPUT: begin
            cmd.out_load = !sts.out_full;
            cmd.out_bad  = bad_ff;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imuacc_pkg::ST_IDLE;
         cnt_ff   <= '0;
         bad_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         bad_ff   <= bad_in;
      end
   end

`ifndef ASSERT_OFF
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !sts.out_full)
      else $error("Result loaded over a waiting result.");

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.take_byte |-> (state_ff == imuacc_pkg::ST_IDLE) && req_valid)
      else $error("Byte taken while a packet is being processed.");

   a_root_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == imuacc_pkg::ST_ROOT) && (state_in == imuacc_pkg::ST_OUTPUT)
      |-> cnt_ff == CntWidth'(imuacc_pkg::RootSteps - 1))
      else $error("Square root left before all steps were done.");
`endif

endmodule

// File: rtl/core/imuacc_dp.sv
// Datapath for the packet decoder: byte framing and checksum, acceleration
// scaling, temperature conversion, square root and the result register.
// Depends on imuacc_pkg.
module imuacc_dp (
   input  logic                clock,
   input  logic                reset,
   input  imuacc_pkg::cmd_type cmd,
   output imuacc_pkg::sts_type sts,
   input  logic [7:0]          rx_byte,
   input  logic [15:0]         gravity_scale,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic signed [16:0]  rsp_accel_x,
   output logic signed [16:0]  rsp_accel_y,
   output logic signed [16:0]  rsp_accel_z,
   output logic signed [14:0]  rsp_temperature_centi,
   output logic [16:0]         rsp_magnitude,
   output logic                rsp_checksum_ok
);

   logic [3:0]                pos_ff, pos_in, pos_eff;
   logic [7:0]                sum_ff, sum_in;
   logic [7:0]                payload_ff [8];
   logic [7:0]                payload_in [8];
   logic [2:0]                wr_idx;

   logic signed [15:0]        raw_t;
   logic signed [15:0]        raw_sel;
   logic signed [32:0]        scale_prod;
   logic signed [16:0]        accel_ff [3];
   logic signed [16:0]        accel_in [3];

   logic signed [18:0]        t_ext, t5;
   logic                      tneg_ff, tneg_in;
   logic [17:0]               tabs_ff, tabs_in;
   logic [37:0]               tq_prod;
   logic [13:0]               tq_ff, tq_in;
   logic signed [14:0]        temp_ff, temp_in;

   logic signed [16:0]        sq_op;
   logic signed [33:0]        sq_prod;
   logic [32:0]               sq_ff, sq_in;
   logic [33:0]               acc_ff, acc_in;
   logic [18:0]               rem_ff, rem_in;
   logic [20:0]               rem_sh;
   logic [18:0]               trial;
   logic [16:0]               root_ff, root_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [16:0]        ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;
   logic signed [14:0]        ot_ff, ot_in;
   logic [16:0]               om_ff, om_in;
   logic                      ok_ff, ok_in;

   // Framing and running checksum.
   always_comb begin
      pos_eff    = (pos_ff > imuacc_pkg::CheckPos) ? 4'd0 : pos_ff;
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      payload_in = payload_ff;
      wr_idx     = 3'(pos_eff - 4'd2);
      if (cmd.take_byte) begin
         pos_in = pos_eff;
         if (pos_eff == 4'd0) begin
            if (rx_byte == imuacc_pkg::HdrFirst) begin
               pos_in = 4'd1;
               sum_in = rx_byte;
            end
         end else if (pos_eff == 4'd1) begin
            if (rx_byte == imuacc_pkg::HdrSecond) begin
               pos_in = 4'd2;
               sum_in = sum_ff + rx_byte;
            end else if (rx_byte == imuacc_pkg::HdrFirst) begin
               sum_in = rx_byte;
            end else begin
               pos_in = 4'd0;
               sum_in = 8'd0;
            end
         end else if (pos_eff < imuacc_pkg::CheckPos) begin
            payload_in[wr_idx] = rx_byte;
            sum_in             = sum_ff + rx_byte;
            pos_in             = pos_eff + 4'd1;
         end else begin
            pos_in = 4'd0;
            sum_in = 8'd0;
         end
      end
   end

   assign sts.at_check  = (pos_eff == imuacc_pkg::CheckPos);
   assign sts.sum_match = (rx_byte == sum_ff);
   assign sts.out_full  = rsp_valid_ff;

   // Acceleration scaling and the three temperature steps share the lane code.
   assign raw_t = $signed({payload_ff[7], payload_ff[6]});

   always_comb begin
      case (cmd.lane)
         2'd0:    raw_sel = $signed({payload_ff[1], payload_ff[0]});
         2'd1:    raw_sel = $signed({payload_ff[3], payload_ff[2]});
         default: raw_sel = $signed({payload_ff[5], payload_ff[4]});
      endcase
      scale_prod = raw_sel * $signed({1'b0, gravity_scale});
      t_ext      = 19'(raw_t);
      t5         = (t_ext <<< 2) + t_ext;
      tq_prod    = tabs_ff * imuacc_pkg::TempRecip;
      accel_in   = accel_ff;
      tneg_in    = tneg_ff;
      tabs_in    = tabs_ff;
      tq_in      = tq_ff;
      temp_in    = temp_ff;
      if (cmd.scale_en) begin
         case (cmd.lane)
            2'd0: begin
               accel_in[0] = scale_prod[31:15];
               tneg_in     = t5[18];
               tabs_in     = t5[18] ? 18'(-t5) : 18'(t5);
            end
            2'd1: begin
               accel_in[1] = scale_prod[31:15];
               tq_in       = 14'(tq_prod >> imuacc_pkg::TempShift);
            end
            default: begin
               accel_in[2] = scale_prod[31:15];
               temp_in     = tneg_ff ? $signed(imuacc_pkg::TempOffset - {1'b0, tq_ff})
                                     : $signed(imuacc_pkg::TempOffset + {1'b0, tq_ff});
            end
         endcase
      end
   end

   // Sum of squares, then a restoring square root, two radicand bits a step.
   always_comb begin
      case (cmd.lane)
         2'd0:    sq_op = accel_ff[0];
         2'd1:    sq_op = accel_ff[1];
         default: sq_op = accel_ff[2];
      endcase
      sq_prod = sq_op * sq_op;
      sq_in   = cmd.sq_load ? sq_prod[32:0] : sq_ff;
      rem_sh  = {rem_ff, acc_ff[33:32]};
      trial   = {root_ff[16:0], 2'b01};
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (cmd.acc_clr) begin
         acc_in  = '0;
         rem_in  = '0;
         root_in = '0;
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + 34'(sq_ff);
      end else if (cmd.root_step) begin
         acc_in = acc_ff << 2;
         if (rem_sh >= 21'(trial)) begin
            rem_in  = 19'(rem_sh - 21'(trial));
            root_in = {root_ff[15:0], 1'b1};
         end else begin
            rem_in  = 19'(rem_sh);
            root_in = {root_ff[15:0], 1'b0};
         end
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      ox_in = ox_ff;
      oy_in = oy_ff;
      oz_in = oz_ff;
      ot_in = ot_ff;
      om_in = om_ff;
      ok_in = ok_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         ox_in = cmd.out_bad ? '0 : accel_ff[0];
         oy_in = cmd.out_bad ? '0 : accel_ff[1];
         oz_in = cmd.out_bad ? '0 : accel_ff[2];
         ot_in = cmd.out_bad ? '0 : temp_ff;
         om_in = cmd.out_bad ? '0 : root_ff;
         ok_in = !cmd.out_bad;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      accel_ff   <= accel_in;
      tneg_ff    <= tneg_in;
      tabs_ff    <= tabs_in;
      tq_ff      <= tq_in;
      temp_ff    <= temp_in;
      sq_ff      <= sq_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      ox_ff      <= ox_in;
      oy_ff      <= oy_in;
      oz_ff      <= oz_in;
      ot_ff      <= ot_in;
      om_ff      <= om_in;
      ok_ff      <= ok_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_accel_x           = ox_ff;
   assign rsp_accel_y           = oy_ff;
   assign rsp_accel_z           = oz_ff;
   assign rsp_temperature_centi = ot_ff;
   assign rsp_magnitude         = om_ff;
   assign rsp_checksum_ok       = ok_ff;

`ifndef ASSERT_OFF
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= imuacc_pkg::CheckPos)
      else $error("Byte position beyond the checksum byte.");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !ok_ff |-> (ox_ff == '0) && (oy_ff == '0) && (oz_ff == '0)
                                 && (ot_ff == '0) && (om_ff == '0))
      else $error("Failed packet carries nonzero fields.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(ox_ff) && $stable(oy_ff)
                                    && $stable(oz_ff) && $stable(ot_ff) && $stable(om_ff)
                                    && $stable(ok_ff))
      else $error("Waiting result changed while stalled.");
`endif

endmodule

// File: sim/accel_packet_checker.sv
`timescale 1ns / 100ps
// Checker for imu_accel_packet_decoder_core: follows every accepted byte and each write to
// GravityAddr, predicts the packet reports and compares them with those the block hands out.
// Depends on imuacc_pkg for the header bytes, the checksum position and the reset scale.
module accel_packet_checker #(
   parameter logic [2:0] GravityAddr = 3'd0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [7:0]          req_rx_byte,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic signed [16:0]  rsp_accel_x,
   input  logic signed [16:0]  rsp_accel_y,
   input  logic signed [16:0]  rsp_accel_z,
   input  logic signed [14:0]  rsp_temperature_centi,
   input  logic [16:0]         rsp_magnitude,
   input  logic                rsp_checksum_ok,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic                csr_pready,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output int                  mismatch_count,
   output int                  outstanding
);

   typedef struct packed {
      logic signed [16:0] accel_x;
      logic signed [16:0] accel_y;
      logic signed [16:0] accel_z;
      logic signed [14:0] temperature_centi;
      logic [16:0]        magnitude;
      logic               checksum_ok;
   } accel_report_type;

   accel_report_type expected_reports[$];
   logic [15:0]      gravity = imuacc_pkg::GravityReset;
   logic [3:0]       byte_pos = '0;
   logic [7:0]       run_sum = '0;
   logic [7:0][7:0]  payload = '0;
   int               errors = 0;

   function automatic logic signed [16:0] scale_axis(input logic [15:0] raw,
                                                     input logic [15:0] g);
      longint prod;
      prod = longint'(signed'(raw)) * longint'(g);
      return 17'(prod >>> 15);
   endfunction

   function automatic logic signed [14:0] centi_degrees(input logic [15:0] raw);
      int t;
      t = int'(signed'(raw)) * 5 / 17 + int'(imuacc_pkg::TempOffset);
      return 15'(t);
   endfunction

   function automatic logic [16:0] floor_root(input longint unsigned n);
      longint unsigned rem;
      longint unsigned root;
      longint unsigned probe;
      rem = n;
      root = 0;
      probe = 64'h1 << 62;
      while (probe > rem) probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return 17'(root);
   endfunction

   function automatic accel_report_type decode_packet(input logic [7:0][7:0] bytes,
                                                      input logic [15:0] g);
      accel_report_type r;
      longint ax;
      longint ay;
      longint az;
      r.accel_x = scale_axis({bytes[1], bytes[0]}, g);
      r.accel_y = scale_axis({bytes[3], bytes[2]}, g);
      r.accel_z = scale_axis({bytes[5], bytes[4]}, g);
      r.temperature_centi = centi_degrees({bytes[7], bytes[6]});
      ax = longint'(r.accel_x);
      ay = longint'(r.accel_y);
      az = longint'(r.accel_z);
      r.magnitude = floor_root(longint'(ax * ax + ay * ay + az * az));
      r.checksum_ok = 1'b1;
      return r;
   endfunction

   always @(posedge clock) begin
      accel_report_type got;
      accel_report_type want;
      logic [7:0]       b;
      if (reset) begin
         gravity = imuacc_pkg::GravityReset;
         byte_pos = '0;
         run_sum = '0;
         payload = '0;
         expected_reports.delete();
         errors = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_accel_x, rsp_accel_y, rsp_accel_z, rsp_temperature_centi,
                    rsp_magnitude, rsp_checksum_ok};
            if (expected_reports.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: report with no request pending: x=%0d y=%0d z=%0d t=%0d",
                           $time, got.accel_x, got.accel_y, got.accel_z,
                           got.temperature_centi);
            end else begin
               want = expected_reports.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: report mismatch, expected x=%0d y=%0d z=%0d t=%0d m=%0d ok=%0d",
                              $time, want.accel_x, want.accel_y, want.accel_z,
                              want.temperature_centi, want.magnitude, want.checksum_ok);
                     $display("%0t:                   got x=%0d y=%0d z=%0d t=%0d m=%0d ok=%0d",
                              $time, got.accel_x, got.accel_y, got.accel_z,
                              got.temperature_centi, got.magnitude, got.checksum_ok);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            b = req_rx_byte;
            if (byte_pos > imuacc_pkg::CheckPos) byte_pos = '0;
            if (byte_pos == 0) begin
               if (b == imuacc_pkg::HdrFirst) begin
                  byte_pos = 4'd1;
                  run_sum = b;
               end
            end else if (byte_pos == 1) begin
               if (b == imuacc_pkg::HdrSecond) begin
                  byte_pos = 4'd2;
                  run_sum = run_sum + b;
               end else if (b == imuacc_pkg::HdrFirst) begin
                  run_sum = b;
               end else begin
                  byte_pos = '0;
                  run_sum = '0;
               end
            end else if (byte_pos < imuacc_pkg::CheckPos) begin
               payload[3'(byte_pos - 4'd2)] = b;
               run_sum = run_sum + b;
               byte_pos = byte_pos + 4'd1;
            end else begin
               byte_pos = '0;
               if (b != run_sum) expected_reports.push_back('0);
               else expected_reports.push_back(decode_packet(payload, gravity));
               run_sum = '0;
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == GravityAddr)
            gravity = csr_pwdata[15:0];
      end
      mismatch_count <= errors;
      outstanding <= expected_reports.size();
   end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Top of the imu_accel_packet_decoder_core testbench: clock, reset, byte and register stimulus
// in phases of scale, idling and output stall, and the verdict. Depends on imuacc_pkg, the block
// itself and accel_packet_checker, which predicts and compares the packet reports.
module testbench;

   localparam logic [2:0] GravityAddr = 3'd0;
   localparam int LongHold = 400;
   localparam int SettleCycles = 30;
   localparam int PhaseBytes = 185;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_rx_byte = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [16:0]  rsp_accel_x;
   logic signed [16:0]  rsp_accel_y;
   logic signed [16:0]  rsp_accel_z;
   logic signed [14:0]  rsp_temperature_centi;
   logic [16:0]         rsp_magnitude;
   logic                rsp_checksum_ok;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [2:0]          csr_paddr = '0;
   logic [31:0]         csr_pwdata = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;
   int                  mismatch_count;
   int                  outstanding;
   int                  send_idle_pct = 0;
   int                  recv_stall_pct = 0;
   int                  bytes_sent = 0;
   logic                long_hold = 1'b0;
   int                  hold_count = 0;

   imu_accel_packet_decoder_core i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_rx_byte           (req_rx_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_accel_x           (rsp_accel_x),
      .rsp_accel_y           (rsp_accel_y),
      .rsp_accel_z           (rsp_accel_z),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_magnitude         (rsp_magnitude),
      .rsp_checksum_ok       (rsp_checksum_ok),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   accel_packet_checker #(
      .GravityAddr (GravityAddr)
   ) i_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_rx_byte           (req_rx_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_accel_x           (rsp_accel_x),
      .rsp_accel_y           (rsp_accel_y),
      .rsp_accel_z           (rsp_accel_z),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_magnitude         (rsp_magnitude),
      .rsp_checksum_ok       (rsp_checksum_ok),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_pready            (csr_pready),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .mismatch_count        (mismatch_count),
      .outstanding           (outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (long_hold && hold_count < LongHold) begin
         rsp_stall <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         if (!long_hold) hold_count <= 0;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_rx_byte <= 8'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_packet(input logic [3:0][15:0] words, input logic corrupt);
      logic [7:0] csum;
      csum = imuacc_pkg::HdrFirst + imuacc_pkg::HdrSecond;
      send_byte(imuacc_pkg::HdrFirst);
      send_byte(imuacc_pkg::HdrSecond);
      for (int i = 0; i < 4; i++) begin
         send_byte(words[i][7:0]);
         send_byte(words[i][15:8]);
         csum = csum + words[i][7:0] + words[i][15:8];
      end
      if (corrupt) csum = csum + 8'($urandom_range(1, 255));
      send_byte(csum);
   endtask

   function automatic logic [3:0][15:0] random_words();
      logic [3:0][15:0] w;
      for (int i = 0; i < 4; i++) begin
         case ($urandom_range(7))
            0: w[i] = 16'h8000;
            1: w[i] = 16'h7FFF;
            2: w[i] = 16'h0000;
            3: w[i] = 16'hFFFF;
            default: w[i] = 16'($urandom);
         endcase
      end
      return w;
   endfunction

   task automatic send_random_chunk();
      int kind;
      int n;
      kind = $urandom_range(99);
      if (kind < 75) begin
         send_packet(random_words(), 1'b0);
      end else if (kind < 85) begin
         send_packet(random_words(), 1'b1);
      end else if (kind < 92) begin
         send_byte(imuacc_pkg::HdrFirst);
         send_byte(imuacc_pkg::HdrSecond);
         n = $urandom_range(7);
         for (int i = 0; i < n; i++) send_byte(8'($urandom));
      end else begin
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++)
            send_byte(($urandom_range(3) == 0) ? imuacc_pkg::HdrFirst : 8'($urandom));
      end
   endtask

   task automatic drain_reports();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_gravity(input logic [15:0] g);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= GravityAddr;
      csr_pwdata <= {16'($urandom), g};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   initial begin
      logic [15:0] grav_set [6];
      int          send_set [6];
      int          recv_set [6];
      int          target;
      logic [15:0] corner;
      grav_set = '{16'd65535, 16'd0, 16'd1, 16'd32768, 16'($urandom),
                   imuacc_pkg::GravityReset};
      send_set = '{0, 79, 0, 38, 0, 79};
      recv_set = '{0, 0, 79, 38, 0, 0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A wrong second header byte, then a doubled first header byte before a good packet and a corrupt one.
      send_byte(imuacc_pkg::HdrFirst);
      send_byte(8'h13);
      send_byte(imuacc_pkg::HdrFirst);
      send_packet({16'h7FFF, 16'h8000, 16'h8000, 16'h8000}, 1'b0);
      send_packet({16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b1);

      for (int phase = 0; phase < 6; phase++) begin
         drain_reports();
         repeat (SettleCycles) @(posedge clock);
         write_gravity(grav_set[phase]);
         send_idle_pct = send_set[phase];
         recv_stall_pct = recv_set[phase];
         corner = phase[0] ? 16'h7FFF : 16'h8000;
         send_packet({corner, corner, corner, corner}, 1'b0);
         if (phase == 4) begin
            long_hold <= 1'b1;
            repeat (3) send_packet(random_words(), 1'b0);
            long_hold <= 1'b0;
         end
         target = bytes_sent + PhaseBytes;
         while (bytes_sent < target) send_random_chunk();
      end

      drain_reports();
      repeat (SettleCycles) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("imu_accel_packet_decoder_core test passed");
      end else begin
         $display("imu_accel_packet_decoder_core test failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("imu_accel_packet_decoder_core test failed");
      $finish;
   end

endmodule
